>>> sv/accumulator_machine_core_macros.svh
// Assertion macros shared by the accumulator machine core RTL.
// No dependencies; take in with `include where assertions are written.
`ifndef ACCUMULATOR_MACHINE_CORE_MACROS_SVH
`define ACCUMULATOR_MACHINE_CORE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define AMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("amc: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define AMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("amc: next-cycle check failed");

`endif

>>> sv/amc_pkg.sv
// Shared types and constants of the accumulator machine core.
// No dependencies.
package amc_pkg;

	localparam int MEM_WORDS_DEF = 256;
	localparam int ADDR_W = 8;
	localparam int WORD_W = 16;
	localparam int CNT_W = 9;

	// access operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_RUN = 2'd2;

	// stop status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	// instruction opcodes (upper byte)
	localparam logic [7:0] OPC_LOAD = 8'd1;
	localparam logic [7:0] OPC_ADD = 8'd2;
	localparam logic [7:0] OPC_STORE = 8'd3;
	localparam logic [7:0] OPC_SUB = 8'd4;
	localparam logic [7:0] OPC_HALT = 8'hFF;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] address;
		logic signed [15:0] write_data;
	} req_word_t;

	typedef struct packed {
		logic signed [15:0] read_data;
		logic signed [15:0] accumulator_value;
		logic [8:0] counter_value;
		logic [1:0] stop_status;
		logic [8:0] steps_done;
	} rsp_word_t;

	// one write port, one read port
	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ACCESS = 6'b000010,
		S_RDATA = 6'b000100,
		S_DECODE = 6'b001000,
		S_EXEC = 6'b010000,
		S_RESULT = 6'b100000
	} state_t;

endpackage

>>> sv/amc_word_mem.sv
// Word store: synchronous single-write, single-read RAM with per-entry valid bits.
// Depends on amc_pkg.
module amc_word_mem
	import amc_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input mem_req_t mem_req,
	output logic [WORD_W-1:0] rdata
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [WORD_W-1:0] mem [MEM_WORDS];
	logic [MEM_WORDS-1:0] valid_q;
	logic [WORD_W-1:0] rdata_q;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;

	assign wa = mem_req.waddr[AW-1:0];
	assign ra = mem_req.raddr[AW-1:0];

	// cleared entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_req.we) begin
			valid_q[wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[wa] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			// write-to-read bypass when both ports hit one entry
			if (mem_req.we && (mem_req.waddr == mem_req.raddr)) begin
				rdata_q <= mem_req.wdata;
			end else if (valid_q[ra]) begin
				rdata_q <= mem[ra];
			end else begin
				rdata_q <= '0;
			end
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/amc_exec.sv
// Sequencer of the accumulator machine core: accesses, fetch/decode/execute, result register.
// Depends on amc_pkg and accumulator_machine_core_macros.svh.
`include "accumulator_machine_core_macros.svh"

module amc_exec
	import amc_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_word_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_word_t rsp,
	output mem_req_t mem_req,
	input logic [WORD_W-1:0] rdata
);

	localparam logic [CNT_W-1:0] MEM_LIMIT = CNT_W'(MEM_WORDS);

	state_t state_q, state_d;
	logic [1:0] op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [WORD_W-1:0] wdata_q;
	logic [WORD_W-1:0] acc_q, acc_d;
	logic [CNT_W-1:0] pc_q, pc_d;
	logic [CNT_W-1:0] steps_q, steps_d;
	logic [1:0] status_q, status_d;
	logic [WORD_W-1:0] rd_q, rd_d;
	logic [7:0] opc_q, opc_d;
	rsp_word_t out_q;
	logic out_valid_q;
	logic out_load;
	logic accept;

	logic [7:0] insn_opc;
	logic [ADDR_W-1:0] insn_opnd;
	logic [CNT_W-1:0] pc_inc;
	logic addr_in_range;
	logic opnd_in_range;
	logic pc_in_range;
	logic pc_inc_in_range;

	assign accept = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);

	assign insn_opc = rdata[15:8];
	assign insn_opnd = rdata[7:0];
	assign pc_inc = pc_q + CNT_W'(1);
	assign addr_in_range = {1'b0, addr_q} < MEM_LIMIT;
	assign opnd_in_range = {1'b0, insn_opnd} < MEM_LIMIT;
	assign pc_in_range = pc_q < MEM_LIMIT;
	assign pc_inc_in_range = pc_inc < MEM_LIMIT;

	always_comb begin
		state_d = state_q;
		acc_d = acc_q;
		pc_d = pc_q;
		steps_d = steps_q;
		status_d = status_q;
		rd_d = rd_q;
		opc_d = opc_q;
		out_load = 1'b0;
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_ACCESS;
					steps_d = '0;
					status_d = ST_DONE;
					rd_d = '0;
				end
			end
			S_ACCESS: begin
				unique case (op_q)
					OP_WRITE: begin
						mem_req.we = addr_in_range;
						mem_req.waddr = addr_q;
						mem_req.wdata = wdata_q;
						state_d = S_RESULT;
					end
					OP_READ: begin
						mem_req.re = addr_in_range;
						mem_req.raddr = addr_q;
						state_d = addr_in_range ? S_RDATA : S_RESULT;
					end
					OP_RUN: begin
						if (pc_in_range) begin
							mem_req.re = 1'b1;
							mem_req.raddr = pc_q[ADDR_W-1:0];
							state_d = S_DECODE;
						end else begin
							status_d = ST_RANGE;
							state_d = S_RESULT;
						end
					end
					default: begin
						state_d = S_RESULT;
					end
				endcase
			end
			S_RDATA: begin
				rd_d = rdata;
				state_d = S_RESULT;
			end
			S_DECODE: begin
				if (insn_opc == OPC_HALT) begin
					status_d = ST_HALT;
					state_d = S_RESULT;
				end else if (insn_opc < OPC_LOAD || insn_opc > OPC_SUB) begin
					status_d = ST_UNKNOWN;
					state_d = S_RESULT;
				end else if (!opnd_in_range) begin
					status_d = ST_RANGE;
					state_d = S_RESULT;
				end else if (insn_opc == OPC_STORE) begin
					// store retires here; next fetch overlaps the write
					mem_req.we = 1'b1;
					mem_req.waddr = insn_opnd;
					mem_req.wdata = acc_q;
					pc_d = pc_inc;
					steps_d = steps_q + CNT_W'(1);
					if (pc_inc_in_range) begin
						mem_req.re = 1'b1;
						mem_req.raddr = pc_inc[ADDR_W-1:0];
					end else begin
						status_d = ST_RANGE;
						state_d = S_RESULT;
					end
				end else begin
					mem_req.re = 1'b1;
					mem_req.raddr = insn_opnd;
					opc_d = insn_opc;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (opc_q)
					OPC_LOAD: acc_d = rdata;
					OPC_ADD: acc_d = acc_q + rdata;
					default: acc_d = acc_q - rdata;
				endcase
				pc_d = pc_inc;
				steps_d = steps_q + CNT_W'(1);
				if (pc_inc_in_range) begin
					mem_req.re = 1'b1;
					mem_req.raddr = pc_inc[ADDR_W-1:0];
					state_d = S_DECODE;
				end else begin
					status_d = ST_RANGE;
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q <= '0;
			pc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q <= acc_d;
			pc_q <= pc_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.operation;
			addr_q <= req.address;
			wdata_q <= $unsigned(req.write_data);
		end
		steps_q <= steps_d;
		status_q <= status_d;
		rd_q <= rd_d;
		opc_q <= opc_d;
		if (out_load) begin
			out_q.read_data <= $signed(rd_q);
			out_q.accumulator_value <= $signed(acc_q);
			out_q.counter_value <= pc_q;
			out_q.stop_status <= status_q;
			out_q.steps_done <= steps_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	`AMC_ASSERT_NOW(a_pc_bound, clk, arst_n, 1'b1, pc_q <= MEM_LIMIT)
	`AMC_ASSERT_NEXT(a_accept_to_access, clk, arst_n, accept, state_q == S_ACCESS)
	`AMC_ASSERT_NOW(a_exec_after_decode, clk, arst_n, state_q == S_EXEC, $past(state_q) == S_DECODE)
	`AMC_ASSERT_NOW(a_write_states, clk, arst_n, mem_req.we, state_q == S_ACCESS || state_q == S_DECODE)
	`AMC_ASSERT_NOW(a_steps_bound, clk, arst_n, rsp_valid, rsp.steps_done <= MEM_LIMIT)

endmodule

>>> sv/accumulator_machine_core.sv
// Accumulator machine core: a small LOAD/ADD/STORE/SUB/HALT processor over a word RAM.
// Each request word writes a word, reads a word, or runs the stored program from the
// kept program counter until HALT, an unknown opcode, the counter leaving memory, or
// an operand beyond memory; one response word comes back per request. Requests are
// taken one at a time. A write passes S_ACCESS and S_RESULT; a read also passes S_RDATA
// unless the address is beyond memory. A run fetches in S_ACCESS, then goes through
// S_DECODE for each instruction and S_EXEC for each LOAD, ADD or SUB, and ends in
// S_RESULT. The operand read of LOAD/ADD/SUB has its own state, S_EXEC. The fetch of
// the next instruction goes out with the accumulate step, or in the same cycle as a
// STORE's write. A finished response sits in an output register, so the next request
// is taken while it waits; a request that finishes while the previous response is
// still untaken holds until that one goes.
// Depends on amc_pkg, amc_word_mem and amc_exec.
module accumulator_machine_core
	import amc_pkg::*;
#(
	// words of RAM, 16 to 256; the program counter runs up to this value
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	// request channel
	input logic req_valid,
	output logic req_ready,
	input req_word_t req,
	// response channel
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_word_t rsp
);

	mem_req_t mem_req;
	logic [WORD_W-1:0] mem_rdata;

	// control: access handling, instruction sequencing, response register
	amc_exec #(
		.MEM_WORDS(MEM_WORDS)
	) u_exec (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.mem_req(mem_req),
		.rdata(mem_rdata)
	);

	// program and data RAM; reads as zero until an entry is written
	amc_word_mem #(
		.MEM_WORDS(MEM_WORDS)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.mem_req(mem_req),
		.rdata(mem_rdata)
	);

endmodule
